// ===== sv/itad_pkg.sv =====
// Shared types, constants and a helper function for the integer to ASCII digits block.
package itad_pkg;

    localparam int VALUE_W       = 64;
    localparam int CHAR_W        = 7;
    localparam int NIB_W         = 4;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int HEX_DIGITS    = VALUE_W / NIB_W;

    localparam logic [NIB_W-1:0]  DEC_RADIX   = 4'd10;
    localparam logic [NIB_W-1:0]  DABBLE_MIN  = 4'd5;
    localparam logic [NIB_W-1:0]  DABBLE_ADJ  = 4'd3;
    localparam logic [CHAR_W-1:0] GLYPH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] GLYPH_ALPHA = 7'h57;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    typedef struct packed {
        logic load;
        logic conv;
        logic trim;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic digit_zero;
        logic count_one;
    } t_sts;

    function automatic logic [CHAR_W-1:0] f_glyph(input logic [NIB_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_RADIX) begin
            c = GLYPH_ZERO + CHAR_W'(d);
        end else begin
            c = GLYPH_ALPHA + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ===== sv/itad_ifs.sv =====
// Valid/ready channel interfaces for the input values and the output characters.
interface itad_in_if;
    logic                          valid;
    logic                          ready;
    logic [itad_pkg::VALUE_W-1:0]  value;
    logic                          mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink (input valid, input value, input mode, output ready);
endinterface

interface itad_out_if;
    logic                          valid;
    logic                          ready;
    logic [itad_pkg::CHAR_W-1:0]   digit_char;
    logic                          last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink (input valid, input digit_char, input last, output ready);
endinterface

// ===== sv/itad_ctrl.sv =====
// Controller state machine that sequences conversion, leading zero trim and emission.
module itad_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output itad_pkg::t_cmd   o_cmd,
    input  itad_pkg::t_sts   i_sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_TRIM = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [itad_pkg::STEP_W-1:0]   r_step;
    logic [itad_pkg::STEP_W-1:0]   n_step;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = (i_in_mode == itad_pkg::MODE_HEX) ? ST_TRIM : ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == itad_pkg::STEP_W'(itad_pkg::CONV_STEPS - 1)) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (i_sts.digit_zero && !i_sts.count_one) begin
                    o_cmd.trim = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.count_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== sv/itad_dp.sv =====
// Datapath holding the binary value, the BCD or hex digit register and the digit count.
module itad_dp #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  itad_pkg::t_cmd                 i_cmd,
    output itad_pkg::t_sts                 o_sts,
    input  logic [itad_pkg::VALUE_W-1:0]   i_value,
    input  logic                           i_mode,
    output logic [itad_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                           o_last
);

    localparam int DW = MAX_DIGITS * itad_pkg::NIB_W;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = $clog2(MAX_DIGITS);

    logic [DW-1:0]                   r_digits;
    logic [DW-1:0]                   n_digits;
    logic [itad_pkg::VALUE_W-1:0]    r_bin;
    logic [itad_pkg::VALUE_W-1:0]    n_bin;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic                            r_ovf;
    logic                            n_ovf;
    logic [DW-1:0]                   v_digits;
    logic [itad_pkg::VALUE_W-1:0]    v_bin;
    logic                            v_ovf;
    logic [CW-1:0]                   w_top;
    logic [IW-1:0]                   w_idx;
    logic [itad_pkg::NIB_W-1:0]      w_digit;

    // Double dabble: BITS_PER_STEP bits of the binary value move into the BCD register per cycle.
    // A one shifted out of the top digit means higher decimal digits were dropped.
    always_comb begin
        v_digits = r_digits;
        v_bin    = r_bin;
        v_ovf    = r_ovf;
        for (int b = 0; b < itad_pkg::BITS_PER_STEP; b++) begin
            for (int j = 0; j < MAX_DIGITS; j++) begin
                if (v_digits[j*itad_pkg::NIB_W +: itad_pkg::NIB_W] >= itad_pkg::DABBLE_MIN) begin
                    v_digits[j*itad_pkg::NIB_W +: itad_pkg::NIB_W] =
                        v_digits[j*itad_pkg::NIB_W +: itad_pkg::NIB_W] + itad_pkg::DABBLE_ADJ;
                end
            end
            v_ovf    = v_ovf | v_digits[DW-1];
            v_digits = {v_digits[DW-2:0], v_bin[itad_pkg::VALUE_W-1]};
            v_bin    = {v_bin[itad_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    assign w_top   = r_count - 1'b1;
    assign w_idx   = w_top[IW-1:0];
    assign w_digit = r_digits[w_idx*itad_pkg::NIB_W +: itad_pkg::NIB_W];

    // Leading zeros are kept when higher decimal digits were dropped.
    assign o_sts.digit_zero = (w_digit == '0) && !r_ovf;
    assign o_sts.count_one  = (r_count == CW'(1));
    assign o_digit_char     = itad_pkg::f_glyph(w_digit);
    assign o_last           = o_sts.count_one;

    always_comb begin
        n_digits = r_digits;
        n_bin    = r_bin;
        n_count  = r_count;
        n_ovf    = r_ovf;
        if (i_cmd.load) begin
            n_bin = i_value;
            n_ovf = 1'b0;
            if (i_mode == itad_pkg::MODE_HEX) begin
                n_digits = DW'(i_value);
                n_count  = CW'(itad_pkg::HEX_DIGITS);
            end else begin
                n_digits = '0;
                n_count  = CW'(MAX_DIGITS);
            end
        end else if (i_cmd.conv) begin
            n_digits = v_digits;
            n_bin    = v_bin;
            n_ovf    = v_ovf;
        end else if (i_cmd.trim || i_cmd.emit) begin
            n_count = w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_bin    <= n_bin;
        r_ovf    <= n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/integer_to_ascii_digits.sv =====
// Top level of the integer to ASCII digits converter.
// The input channel carries a 64-bit unsigned value and a mode bit (0 decimal, 1 hexadecimal).
// The output channel returns the value's digits as ASCII, most significant first,
// lower-case for hex, with no leading zeros; a zero value gives a single '0'.
// The last flag marks the final, least significant digit of each number.
// One value is handled at a time: the input is ready only while the block is idle.
// Decimal values pass through a double dabble converter that takes 4 bits per cycle;
// hex values need no conversion.
// Leading zeros are then dropped at one digit per cycle.
// Each digit is then presented for one transfer.
// A stalled receiver simply holds the current digit; nothing is lost or repeated.
// A new value is accepted in the cycle after the transfer of the last digit.
// Synchronous reset returns the controller to idle with the input ready.
// With MAX_DIGITS below 20, only the low MAX_DIGITS decimal digits are returned,
// and a value longer than that keeps any leading zeros among those digits.
module integer_to_ascii_digits #(
    parameter int MAX_DIGITS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    itad_in_if.sink       i_in,
    itad_out_if.source    o_out
);

    itad_pkg::t_cmd w_cmd;
    itad_pkg::t_sts w_sts;

    itad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    itad_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_value      (i_in.value),
        .i_mode       (i_in.mode),
        .o_digit_char (o_out.digit_char),
        .o_last       (o_out.last)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("Input ready while a digit is presented.");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> (i_in.ready && !o_out.valid))
        else $error("Block not idle after the final digit transfer.");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.digit_char >= 7'h30 && o_out.digit_char <= 7'h39)
                      || (o_out.digit_char >= 7'h61 && o_out.digit_char <= 7'h66)))
        else $error("Digit character outside the digit alphabet.");

    a_single_after_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (!i_in.ready && !o_out.valid) || o_out.valid)
        else $error("Input accepted again right after a transfer.");
`endif

endmodule
